FILE: rtl/core/moving_mean_difference_filter_assert.svh
// Assertion macros shared by the filter's checkers.
`ifndef MOVING_MEAN_DIFFERENCE_FILTER_ASSERT_SVH
`define MOVING_MEAN_DIFFERENCE_FILTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MMDF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MMDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mmdf_pkg.sv
// Package for the moving mean difference filter: widths, defaults and state type.
`timescale 1ns / 1ps
`default_nettype none
package mmdf_pkg;

  localparam int SAMPLE_W   = 18;
  localparam int OUT_W      = 19;
  localparam int WINDOW_DEF = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_LD,
    S_SER,
    S_ABS,
    S_DIV,
    S_NEG,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/core/mmdf_sdiv.sv
// Bit-serial restoring divider: unsigned dividend by a narrow unsigned divisor.
`timescale 1ns / 1ps
`default_nettype none
module mmdf_sdiv #(
  parameter int SW = 22,
  parameter int CW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [SW-1:0] dividend,
  input  logic [CW-1:0] divisor,
  output logic          done,
  output logic [SW-1:0] quotient
);
  localparam int CNTW = $clog2(SW);

  logic            run_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [SW-1:0]   dvd_r;
  logic [CW-1:0]   rem_r;
  logic [CW-1:0]   dsr_r;
  logic [CW+1:0]   trial;
  logic            qbit;
  logic [CW-1:0]   rem_nxt;

  always_comb begin
    trial   = {1'b0, rem_r, dvd_r[SW-1]} - {2'b00, dsr_r};
    qbit    = ~trial[CW+1];
    rem_nxt = qbit ? trial[CW-1:0] : {rem_r[CW-2:0], dvd_r[SW-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && !start && (cnt_r == CNTW'(SW - 1));
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNTW'(SW - 1)) run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (run_r) begin
      dvd_r <= {dvd_r[SW-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule
`default_nettype wire

FILE: rtl/core/moving_mean_difference_filter.sv
// Top level of the moving mean difference filter.
// Usage:
//   Input channel in_valid/in_stall/in_sample takes one signed 18-bit sample per item.
//   Output channel out_valid/out_stall/out_mean_minus_sample gives one signed 19-bit
//   result per item: the window mean (truncated toward zero) minus the sample.
//   One item is in flight at a time. From accept to result an item passes the memory read,
//   load, bit-serial sum update over SW = 18 + clog2(WINDOW) bits, abs, bit-serial divide
//   by the fill count, sign and output steps, in that order.
//   in_stall is high during reset and while an item is in work; the next item is
//   taken as soon as the block is back in idle, even while the last result still
//   waits at the output.
//   A stalled result holds in the output register; the block waits before loading
//   a new one.
//   Reset (rst_n low, synchronous) empties the window, zeroes the sum, position and
//   fill count. Ring entries not yet written read as zero through the fill count,
//   so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module moving_mean_difference_filter #(
  parameter int WINDOW = mmdf_pkg::WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [mmdf_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mmdf_pkg::OUT_W-1:0]   out_mean_minus_sample
);
  import mmdf_pkg::*;

  localparam int SW   = SAMPLE_W + $clog2(WINDOW);
  localparam int PW   = $clog2(WINDOW);
  localparam int CW   = $clog2(WINDOW + 1);
  localparam int CNTW = $clog2(SW);

  state_t state_r, state_nxt;

  logic [SAMPLE_W-1:0] mem_r [WINDOW];
  logic [SAMPLE_W-1:0] rd_r;
  logic [SAMPLE_W-1:0] x_r;
  logic [PW-1:0]       pos_r;
  logic [PW-1:0]       addr_r;
  logic [CW-1:0]       fill_r;
  logic                full_r;
  logic [SW-1:0]       sum_r;
  logic [SW-1:0]       old_sr;
  logic [SW-1:0]       x_sr;
  logic                c1_r, c2_r;
  logic [CNTW-1:0]     ser_cnt_r;
  logic                neg_r;
  logic [OUT_W-1:0]    mean_r;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_r;

  logic                in_take;
  logic                div_start;
  logic                div_done;
  logic [SW-1:0]       div_q;
  logic [SW-1:0]       abs_sum;
  logic                s_b, o_b, x_b, a_b, r_b, c1_nxt, c2_nxt;
  logic                out_free;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign abs_sum  = sum_r[SW-1] ? (~sum_r + 1'b1) : sum_r;

  // serial sum update: sum - old + x, one bit per cycle, LSB first
  always_comb begin
    s_b    = sum_r[0];
    o_b    = ~old_sr[0];
    x_b    = x_sr[0];
    a_b    = s_b ^ o_b ^ c1_r;
    c1_nxt = (s_b & o_b) | (s_b & c1_r) | (o_b & c1_r);
    r_b    = a_b ^ x_b ^ c2_r;
    c2_nxt = (a_b & x_b) | (a_b & c2_r) | (x_b & c2_r);
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = !rst_n || (state_r != S_IDLE);
    div_start = 1'b0;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_RD;
      S_RD:   state_nxt = S_LD;
      S_LD:   state_nxt = S_SER;
      S_SER:  if (ser_cnt_r == CNTW'(SW - 1)) state_nxt = S_ABS;
      S_ABS: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV:  if (div_done) state_nxt = S_NEG;
      S_NEG:  state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      ser_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_take) begin
        pos_r <= (pos_r == PW'(WINDOW - 1)) ? '0 : pos_r + 1'b1;
        if (fill_r != CW'(WINDOW)) fill_r <= fill_r + 1'b1;
      end
      if (state_r == S_LD) ser_cnt_r <= '0;
      if (state_r == S_SER) begin
        sum_r     <= {r_b, sum_r[SW-1:1]};
        ser_cnt_r <= ser_cnt_r + 1'b1;
      end
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      x_r    <= in_sample;
      addr_r <= pos_r;
      full_r <= (fill_r == CW'(WINDOW));
    end
    if (state_r == S_RD) rd_r <= mem_r[addr_r];
    if (state_r == S_ABS) mem_r[addr_r] <= x_r;
    if (state_r == S_LD) begin
      old_sr <= full_r ? {{(SW-SAMPLE_W){rd_r[SAMPLE_W-1]}}, rd_r} : '0;
      x_sr   <= {{(SW-SAMPLE_W){x_r[SAMPLE_W-1]}}, x_r};
      c1_r   <= 1'b1;
      c2_r   <= 1'b0;
    end
    if (state_r == S_SER) begin
      old_sr <= {old_sr[SW-1], old_sr[SW-1:1]};
      x_sr   <= {x_sr[SW-1], x_sr[SW-1:1]};
      c1_r   <= c1_nxt;
      c2_r   <= c2_nxt;
    end
    if (state_r == S_ABS) neg_r <= sum_r[SW-1];
    if (state_r == S_NEG) mean_r <= neg_r ? (~div_q[OUT_W-1:0] + 1'b1) : div_q[OUT_W-1:0];
    if (state_r == S_OUT && out_free) out_r <= mean_r - {x_r[SAMPLE_W-1], x_r};
  end

  mmdf_sdiv #(
    .SW(SW),
    .CW(CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (abs_sum),
    .divisor  (fill_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_valid             = out_valid_r;
  assign out_mean_minus_sample = out_r;

endmodule
`default_nettype wire

FILE: rtl/core/mmdf_checker.sv
// Port-level checker for the moving mean difference filter, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module mmdf_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [mmdf_pkg::OUT_W-1:0]        out_mean_minus_sample
);
  import mmdf_pkg::*;
`include "moving_mean_difference_filter_assert.svh"

  `MMDF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `MMDF_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_mean_minus_sample), "stalled result changed")
  `MMDF_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second item taken while busy")
  `MMDF_ASSERT_NOW(a_out_range, out_valid, (out_mean_minus_sample != {1'b1, {(OUT_W-1){1'b0}}}), "result out of range")

endmodule

bind moving_mean_difference_filter mmdf_checker u_mmdf_checker (.*);
`default_nettype wire

FILE: bench/mean_diff_checker.sv
// Checker for the moving mean difference filter: predicts each item's result and compares.
`timescale 1ns / 1ps
module mean_diff_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic signed [mmdf_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [mmdf_pkg::OUT_W-1:0]    out_mean_minus_sample,
  output int                                   pending_diffs,
  output int                                   mismatch_count
);

  localparam int SW     = mmdf_pkg::SAMPLE_W;
  localparam int OW     = mmdf_pkg::OUT_W;
  localparam int WIN    = mmdf_pkg::WINDOW_DEF;
  localparam int SUM_W  = SW + $clog2(WIN);
  localparam int POS_W  = $clog2(WIN);
  localparam int FILL_W = $clog2(WIN) + 1;

  logic signed [SW-1:0]    ring [WIN];
  logic signed [SUM_W-1:0] window_sum;
  logic [POS_W-1:0]        wr_pos;
  logic [FILL_W-1:0]       fill;
  logic signed [OW-1:0]    expected_diffs [$];
  int                      result_idx;

  task automatic predict_mean_diff(input logic signed [SW-1:0] x,
                                   output logic signed [OW-1:0] diff);
    logic signed [SUM_W-1:0] mean;
    logic signed [SUM_W:0]   d;
    window_sum = window_sum - ring[wr_pos] + x;
    ring[wr_pos] = x;
    wr_pos = POS_W'((wr_pos + 1) % WIN);
    if (fill < WIN) fill = fill + 1'b1;
    // signed division truncates toward zero
    mean = window_sum / $signed({1'b0, fill});
    d = mean - x;
    diff = d[OW-1:0];
  endtask

  always @(posedge clk) begin : watch
    logic signed [OW-1:0] want;
    int i;
    if (!rst_n) begin
      for (i = 0; i < WIN; i++) ring[i] = '0;
      window_sum = '0;
      wr_pos = '0;
      fill = '0;
      expected_diffs.delete();
      result_idx = 0;
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_diffs.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: none expected, got %0d", result_idx, out_mean_minus_sample);
        end else begin
          want = expected_diffs.pop_front();
          if (out_mean_minus_sample !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result %0d: expected %0d, got %0d", result_idx, want,
                       out_mean_minus_sample);
          end
        end
        result_idx++;
      end
      if (in_valid && !in_stall) begin
        predict_mean_diff(in_sample, want);
        expected_diffs.push_back(want);
      end
    end
    pending_diffs <= expected_diffs.size();
  end

endmodule

FILE: bench/tb_top.sv
// Testbench top for the moving mean difference filter: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int SW          = mmdf_pkg::SAMPLE_W;
  localparam int OW          = mmdf_pkg::OUT_W;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_RANDOM    = 1000;
  localparam logic signed [SW-1:0] S_MAX = SW'((1 <<< (SW - 1)) - 1);
  localparam logic signed [SW-1:0] S_MIN = SW'(-(1 <<< (SW - 1)));

  typedef enum int {RUN_MAX, RUN_MIN, RUN_ALT, RUN_SMALL, RUN_NEAR, RUN_FULL} run_kind_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [SW-1:0] in_sample = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [OW-1:0] out_mean_minus_sample;
  logic                 idle_en = 1'b0;
  int                   stall_left = 0;
  int                   cycle_count = 0;
  int                   pending_diffs;
  int                   mismatch_count;

  logic signed [SW-1:0] directed_samples [20] = '{
    SW'(0), S_MAX, S_MIN, SW'(-1), SW'(1), S_MAX, S_MAX, S_MIN, S_MIN, SW'(-3),
    SW'(5), SW'(-7), SW'(2), S_MAX, S_MIN, SW'(12345), SW'(-12345), SW'(0), SW'(1), SW'(-1)
  };

  moving_mean_difference_filter dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_sample             (in_sample),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_mean_minus_sample (out_mean_minus_sample)
  );

  mean_diff_checker checker_i (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_sample             (in_sample),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_mean_minus_sample (out_mean_minus_sample),
    .pending_diffs         (pending_diffs),
    .mismatch_count        (mismatch_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("moving_mean_difference_filter verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!idle_en) begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic signed [SW-1:0] pick_sample(run_kind_t kind);
    logic signed [SW-1:0] v;
    case (kind)
      RUN_MAX:   v = S_MAX;
      RUN_MIN:   v = S_MIN;
      RUN_ALT:   v = $urandom_range(0, 1) ? S_MAX : S_MIN;
      RUN_SMALL: v = SW'($urandom_range(0, 16)) - SW'(8);
      RUN_NEAR:  v = $urandom_range(0, 1) ? S_MAX - SW'($urandom_range(0, 15))
                                         : S_MIN + SW'($urandom_range(0, 15));
      default:   v = SW'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_item(input logic signed [SW-1:0] v, input bit may_idle);
    if (may_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      in_sample <= SW'($urandom);
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_diffs != 0);
  endtask

  initial begin
    int        k;
    int        run_left;
    bit        quiet;
    run_kind_t kind;
    run_left = 0;
    quiet = 1'b1;
    kind = RUN_FULL;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < $size(directed_samples); k++) send_item(directed_samples[k], 1'b0);
    wait_drained();

    for (k = 0; k < N_RANDOM; k++) begin
      if (k % 100 == 0) begin
        if (k == 500) wait_drained();
        quiet = (k >= N_RANDOM - 150) || ($urandom_range(0, 3) == 0);
        idle_en <= !quiet;
      end
      if (run_left == 0) begin
        case ($urandom_range(0, 9))
          0:       kind = RUN_MAX;
          1:       kind = RUN_MIN;
          2:       kind = RUN_ALT;
          3:       kind = RUN_SMALL;
          4:       kind = RUN_NEAR;
          default: kind = RUN_FULL;
        endcase
        run_left = $urandom_range(1, 24);
      end
      run_left--;
      send_item(pick_sample(kind), !quiet);
    end

    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("moving_mean_difference_filter verification clean");
    end else begin
      $display("moving_mean_difference_filter verification failed");
    end
    $finish;
  end

endmodule
